/* rtl/egv_pkg.sv */
// ----------------------------------------------------------------------------
// egv_pkg
// Shared types and constants for the envelope generator and amplifier.
// ----------------------------------------------------------------------------
package egv_pkg;

	localparam int LEN_BITS_DEF = 24;
	localparam int LVL_BITS     = 16;
	localparam int Q_BITS       = 16;
	localparam int IDX_BITS     = 3;
	localparam logic [LVL_BITS:0] LVL_ONE = 17'd32768;

	localparam logic [IDX_BITS-1:0] REG_TERMINAL = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_DELAY    = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_ATTACK   = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_DECAY    = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_SUSTAIN  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_RELEASE  = 3'd5;
	localparam logic [IDX_BITS-1:0] REG_PEAK     = 3'd6;
	localparam logic [IDX_BITS-1:0] REG_HOLD     = 3'd7;

	typedef struct packed {
		logic [31:0]        frame_index;
		logic signed [15:0] in_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [15:0] out_sample;
		logic               active;
	} out_item_t;

endpackage

/* rtl/envelope_generator_vca_unit.sv */
// ----------------------------------------------------------------------------
// envelope_generator_vca_unit
// Five-segment linear envelope evaluated per frame index, applied to the
// input sample or output alone; pipelined ramp divider.
//
//   channel   direction   handshake              payload
//   in        request in  in_valid / in_stall    frame_index, in_sample
//   out       request out out_valid / out_stall  out_sample, active
//   cfg       write in    cfg_we                 cfg_index, cfg_data
//
// one request per cycle while no finished result is stalled at the output
// the pipeline is segment select, multiplier, 16 divider steps and vca stages
// reset clears the valid bits and sets the config registers to defaults, no clearing pass
// the whole pipeline holds while a finished result is stalled at the output
// ----------------------------------------------------------------------------
module envelope_generator_vca_unit #(
	parameter int LEN_BITS = egv_pkg::LEN_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  egv_pkg::in_item_t                    in_data,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output egv_pkg::out_item_t                   out_data,
	input  logic                                 cfg_we,
	input  logic [egv_pkg::IDX_BITS-1:0]         cfg_index,
	input  logic [(LEN_BITS > 16 ? LEN_BITS : 16)-1:0] cfg_data
);
	import egv_pkg::*;

	localparam int EW = LEN_BITS + 3;
	localparam int CW = (EW > 32) ? EW : 32;
	localparam int NW = LEN_BITS + Q_BITS;

	typedef struct packed {
		logic [LVL_BITS:0]  base;
		logic               sub;
		logic               active;
		logic signed [15:0] sample;
		logic               mode;
	} carry_t;

	// configuration
	logic                term_q;
	logic [LEN_BITS-1:0] dly_q, att_q, dec_q, sus_q, rel_q;
	logic [15:0]         peak_q, hold_q;
	logic [EW-1:0]       end1_q, end2_q, end3_q, end4_q, end5_q;
	logic [LVL_BITS:0]   pk, hd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_q <= 1'b0;
			dly_q  <= '0;
			att_q  <= '0;
			dec_q  <= '0;
			sus_q  <= '0;
			rel_q  <= '0;
			peak_q <= 16'd32768;
			hold_q <= 16'd16384;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TERMINAL: term_q <= cfg_data[0];
				REG_DELAY:    dly_q  <= cfg_data[LEN_BITS-1:0];
				REG_ATTACK:   att_q  <= cfg_data[LEN_BITS-1:0];
				REG_DECAY:    dec_q  <= cfg_data[LEN_BITS-1:0];
				REG_SUSTAIN:  sus_q  <= cfg_data[LEN_BITS-1:0];
				REG_RELEASE:  rel_q  <= cfg_data[LEN_BITS-1:0];
				REG_PEAK:     peak_q <= cfg_data[15:0];
				REG_HOLD:     hold_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// segment boundaries, taken from the lengths being written
	logic [LEN_BITS-1:0] dly_n, att_n, dec_n, sus_n, rel_n;
	logic [EW-1:0]       da_n, ds_n;

	assign dly_n = (cfg_we && cfg_index == REG_DELAY)   ? cfg_data[LEN_BITS-1:0] : dly_q;
	assign att_n = (cfg_we && cfg_index == REG_ATTACK)  ? cfg_data[LEN_BITS-1:0] : att_q;
	assign dec_n = (cfg_we && cfg_index == REG_DECAY)   ? cfg_data[LEN_BITS-1:0] : dec_q;
	assign sus_n = (cfg_we && cfg_index == REG_SUSTAIN) ? cfg_data[LEN_BITS-1:0] : sus_q;
	assign rel_n = (cfg_we && cfg_index == REG_RELEASE) ? cfg_data[LEN_BITS-1:0] : rel_q;
	assign da_n  = EW'(dly_n) + EW'(att_n);
	assign ds_n  = EW'(dec_n) + EW'(sus_n);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end1_q <= '0;
			end2_q <= '0;
			end3_q <= '0;
			end4_q <= '0;
			end5_q <= '0;
		end else begin
			end1_q <= EW'(dly_n);
			end2_q <= da_n;
			end3_q <= da_n + EW'(dec_n);
			end4_q <= da_n + ds_n;
			end5_q <= da_n + ds_n + EW'(rel_n);
		end
	end

	assign pk = ({1'b0, peak_q} > LVL_ONE) ? LVL_ONE : {1'b0, peak_q};
	assign hd = ({1'b0, hold_q} > LVL_ONE) ? LVL_ONE : {1'b0, hold_q};

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: segment select
	logic [CW-1:0]       fz, seg_start;
	logic [LEN_BITS-1:0] len_c;
	logic [15:0]         dlt_c;
	carry_t              cy_c;

	always_comb begin
		fz             = CW'(in_data.frame_index);
		seg_start      = '0;
		len_c          = LEN_BITS'(1);
		dlt_c          = '0;
		cy_c.base      = '0;
		cy_c.sub       = 1'b0;
		cy_c.active    = 1'b1;
		cy_c.sample    = in_data.in_sample;
		cy_c.mode      = term_q;
		if (fz >= CW'(end5_q)) begin
			cy_c.active = 1'b0;
		end else if (fz >= CW'(end4_q)) begin
			seg_start = CW'(end4_q);
			len_c     = rel_q;
			dlt_c     = hd[15:0] | {hd[16], 15'd0};
			cy_c.base = hd;
			cy_c.sub  = 1'b1;
		end else if (fz >= CW'(end3_q)) begin
			cy_c.base = hd;
		end else if (fz >= CW'(end2_q)) begin
			seg_start = CW'(end2_q);
			len_c     = dec_q;
			cy_c.base = pk;
			cy_c.sub  = (pk >= hd);
			dlt_c     = (pk >= hd) ? 16'(pk - hd) : 16'(hd - pk);
		end else if (fz >= CW'(end1_q)) begin
			seg_start = CW'(end1_q);
			len_c     = att_q;
			dlt_c     = pk[15:0] | {pk[16], 15'd0};
		end
	end

	logic                v_s1;
	logic [LEN_BITS-1:0] off_s1, len_s1;
	logic [15:0]         dlt_s1;
	carry_t              cy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			off_s1 <= LEN_BITS'(fz - seg_start);
			len_s1 <= len_c;
			dlt_s1 <= dlt_c;
			cy_s1  <= cy_c;
		end
	end

	// stage 2 and divider chain: index 0 is the product stage
	logic                dv_v   [0:Q_BITS];
	logic [NW-1:0]       dv_rem [0:Q_BITS];
	logic [LEN_BITS-1:0] dv_len [0:Q_BITS];
	logic [Q_BITS-1:0]   dv_q   [0:Q_BITS];
	carry_t              dv_cy  [0:Q_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_v[0] <= 1'b0;
		else if (en) dv_v[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_rem[0] <= NW'(off_s1 * dlt_s1);
			dv_len[0] <= len_s1;
			dv_q[0]   <= '0;
			dv_cy[0]  <= cy_s1;
		end
	end

	for (genvar j = 0; j < Q_BITS; j++) begin : g_div
		localparam int SH = Q_BITS - 1 - j;
		logic [NW-1:0] dsh;
		logic          ge;
		assign dsh = NW'(dv_len[j]) << SH;
		assign ge  = (dv_rem[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[j+1] <= 1'b0;
			else if (en) dv_v[j+1] <= dv_v[j];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_rem[j+1] <= ge ? (dv_rem[j] - dsh) : dv_rem[j];
				dv_len[j+1] <= dv_len[j];
				dv_q[j+1]   <= {dv_q[j][Q_BITS-2:0], ge};
				dv_cy[j+1]  <= dv_cy[j];
			end
		end
	end

	// stage 19: level and vca product
	carry_t             cyd;
	logic [LVL_BITS:0]  lvl;
	assign cyd = dv_cy[Q_BITS];
	assign lvl = cyd.sub ? (cyd.base - (LVL_BITS+1)'(dv_q[Q_BITS]))
	                     : (cyd.base + (LVL_BITS+1)'(dv_q[Q_BITS]));

	logic               v_s19;
	logic signed [33:0] prod_s19;
	logic [LVL_BITS:0]  lvl_s19;
	logic               act_s19, mode_s19;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s19 <= 1'b0;
		else if (en) v_s19 <= dv_v[Q_BITS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s19 <= 34'(cyd.sample * $signed({1'b0, lvl}));
			lvl_s19  <= lvl;
			act_s19  <= cyd.active;
			mode_s19 <= cyd.mode;
		end
	end

	// stage 20: scaling, saturation and output register
	logic signed [33:0] shf;
	logic signed [15:0] res;
	assign shf = prod_s19 >>> 15;

	always_comb begin
		if (!act_s19) begin
			res = '0;
		end else if (mode_s19) begin
			res = (lvl_s19 > 17'd32767) ? 16'sd32767 : $signed(lvl_s19[15:0]);
		end else if (shf > 34'sd32767) begin
			res = 16'sd32767;
		end else if (shf < -34'sd32768) begin
			res = -16'sd32768;
		end else begin
			res = shf[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= v_s19;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data.out_sample <= res;
			out_data.active     <= act_s19;
		end
	end

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.active |-> out_data.out_sample == 16'sd0)
		else $error("inactive result not zero");

	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output stall");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the envelope generator and amplifier. Every
// accepted request is run through a Q1.15 envelope predictor. Each result
// is compared field by field with the oldest expected sample. Directed
// phases cover these cases:
//   - zero total length and zero-length segments
//   - levels written above 1.0, and a hold level above the peak
//   - the longest segments, and frames past the end
//   - extreme samples, in both output modes
// Random phases follow, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import egv_pkg::*;

	class vca_predictor;
		logic        terminal;
		logic [23:0] seg_len [5];
		logic [15:0] peak_raw, hold_raw;
		out_item_t   expected_samples [$];
		int          errors;
		int          checked;

		function new();
			terminal = 0;
			foreach (seg_len[k]) seg_len[k] = '0;
			peak_raw = 16'd32768;
			hold_raw = 16'd16384;
			errors = 0;
			checked = 0;
		endfunction

		function longint unsigned total_len();
			longint unsigned t;
			t = 0;
			foreach (seg_len[k]) t += seg_len[k];
			return t;
		endfunction

		function longint unsigned level_at(longint unsigned f);
			longint unsigned pk, hd, l;
			pk = (peak_raw > 16'd32768) ? 32768 : peak_raw;
			hd = (hold_raw > 16'd32768) ? 32768 : hold_raw;
			l = seg_len[0];
			if (f < l) return 0;
			f -= l;
			l = seg_len[1];
			if (f < l) return (f * pk) / l;
			f -= l;
			l = seg_len[2];
			if (f < l) begin
				if (pk >= hd) return pk - (f * (pk - hd)) / l;
				return pk + (f * (hd - pk)) / l;
			end
			f -= l;
			l = seg_len[3];
			if (f < l) return hd;
			f -= l;
			l = seg_len[4];
			if (f < l) return hd - (f * hd) / l;
			return 0;
		endfunction

		function void note_request(in_item_t rq);
			out_item_t       x;
			longint unsigned e;
			longint          p;
			if (rq.frame_index >= total_len()) begin
				x.out_sample = '0;
				x.active = 1'b0;
			end else begin
				e = level_at(rq.frame_index);
				if (terminal) begin
					x.out_sample = (e > 32767) ? 16'sd32767 : 16'(e);
				end else begin
					p = longint'(rq.in_sample) * longint'(e);
					p = p >>> 15;
					if (p > 32767) p = 32767;
					if (p < -32768) p = -32768;
					x.out_sample = 16'(p);
				end
				x.active = 1'b1;
			end
			expected_samples = {expected_samples, x};
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (expected_samples.size() == 0) begin
				report("result with no request pending");
			end else begin
				want = expected_samples.pop_front();
				checked++;
				if (got.out_sample !== want.out_sample)
					report($sformatf("out_sample %0d, expected %0d",
						got.out_sample, want.out_sample));
				if (got.active !== want.active)
					report($sformatf("active %0b, expected %0b", got.active, want.active));
			end
		endtask
	endclass

	localparam int NUM_ITEMS = 1450;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_item_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_item_t   out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;

	vca_predictor envelope = new();
	int  sent;
	int  phases;
	int  cycles;
	bit  quiet;

	envelope_generator_vca_unit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) envelope.note_request(in_data);
			if (out_valid && !out_stall) envelope.check_result(out_data);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet && $urandom_range(0, 5) == 0) begin
				out_stall = 1;
				repeat ($urandom_range(1, 3)) @(negedge clk);
				out_stall = 0;
			end
		end
	end

	task write_reg(logic [2:0] idx, logic [23:0] val);
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		case (idx)
			REG_TERMINAL: envelope.terminal = val[0];
			REG_DELAY:    envelope.seg_len[0] = val;
			REG_ATTACK:   envelope.seg_len[1] = val;
			REG_DECAY:    envelope.seg_len[2] = val;
			REG_SUSTAIN:  envelope.seg_len[3] = val;
			REG_RELEASE:  envelope.seg_len[4] = val;
			REG_PEAK:     envelope.peak_raw = val[15:0];
			REG_HOLD:     envelope.hold_raw = val[15:0];
			default: ;
		endcase
	endtask

	task drain();
		while (envelope.expected_samples.size() != 0) @(negedge clk);
		repeat (25) @(negedge clk);
	endtask

	task set_envelope(bit mode, int d, int a, int dc, int s, int r, int pk, int hd);
		drain();
		write_reg(REG_TERMINAL, 24'(mode));
		write_reg(REG_DELAY, 24'(d));
		write_reg(REG_ATTACK, 24'(a));
		write_reg(REG_DECAY, 24'(dc));
		write_reg(REG_SUSTAIN, 24'(s));
		write_reg(REG_RELEASE, 24'(r));
		write_reg(REG_PEAK, 24'(pk));
		write_reg(REG_HOLD, 24'(hd));
		phases++;
	endtask

	task send_request(logic [31:0] f, logic [15:0] smp);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid = 0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid = 1;
		in_data.frame_index = f;
		in_data.in_sample = smp;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid = 0;
		sent++;
		if (sent > NUM_ITEMS - 150) quiet = 1;
	endtask

	function int rand_len();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 24'hFFFFFF);
			default: return $urandom_range(1, 40);
		endcase
	endfunction

	function int rand_level();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 32768;
			2: return $urandom_range(32769, 65535);
			default: return $urandom_range(0, 32768);
		endcase
	endfunction

	function logic [15:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task random_request();
		longint unsigned t;
		logic [31:0]     f;
		t = envelope.total_len();
		case ($urandom_range(0, 9))
			0: f = $urandom;
			1: f = 32'(t) + $urandom_range(0, 3);
			default: f = (t == 0) ? $urandom : $urandom_range(0, 32'(t - 1));
		endcase
		send_request(f, rand_sample());
	endtask

	initial begin
		int n;
		arst_n = 0;
		in_valid = 0;
		in_data = '0;
		cfg_we = 0;
		cfg_index = REG_TERMINAL;
		cfg_data = '0;
		sent = 0;
		phases = 0;
		cycles = 0;
		quiet = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// reset defaults: zero total length
		send_request(32'd0, 16'h7FFF);
		send_request(32'hFFFFFFFF, 16'h8000);
		// all five segments, stepped one frame at a time
		set_envelope(1, 2, 4, 4, 3, 4, 32768, 16384);
		for (int i = 0; i < 18; i++) send_request(i, 16'h7FFF);
		// levels above 1.0, hold above peak, extreme samples
		set_envelope(0, 0, 3, 4, 0, 2, 40000, 65535);
		send_request(32'd2, 16'h8000);
		send_request(32'd5, 16'h7FFF);
		send_request(32'd7, 16'h8000);
		send_request(32'd8, 16'h0000);
		set_envelope(0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
			24'hFFFFFF, 1000, 30000);
		send_request(32'd83886074, 16'h7FFF);
		send_request(32'd83886075, 16'h7FFF);
		send_request(32'd25165823, 16'h8000);

		while (sent < NUM_ITEMS) begin
			set_envelope($urandom_range(0, 1), rand_len(), rand_len(), rand_len(),
				rand_len(), rand_len(), rand_level(), rand_level());
			n = $urandom_range(40, 100);
			for (int i = 0; i < n && sent < NUM_ITEMS; i++) random_request();
		end
		in_valid = 0;

		while (envelope.expected_samples.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		$display("%0d requests over %0d envelope settings, %0d results checked",
			sent, phases, envelope.checked);
		if (envelope.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
